FILE: rtl/fpmisc_pkg.sv
// shared types and operation codes for the floating-point misc operate unit
// no dependencies
package fpmisc_pkg;

  localparam int unsigned OpWidth   = 4;
  localparam int unsigned WordWidth = 64;

  typedef logic [OpWidth-1:0]   op_t;
  typedef logic [WordWidth-1:0] word_t;

  localparam op_t OP_CPYS    = 4'd0;
  localparam op_t OP_CPYSE   = 4'd1;
  localparam op_t OP_CPYSN   = 4'd2;
  localparam op_t OP_CVTLQ   = 4'd3;
  localparam op_t OP_CVTQL   = 4'd4;
  localparam op_t OP_CMOVEQ  = 4'd5;
  localparam op_t OP_CMOVGE  = 4'd6;
  localparam op_t OP_CMOVGT  = 4'd7;
  localparam op_t OP_CMOVLE  = 4'd8;
  localparam op_t OP_CMOVLT  = 4'd9;
  localparam op_t OP_CMOVNE  = 4'd10;
  localparam op_t OP_RD_CTL  = 4'd11;
  localparam op_t OP_WR_CTL  = 4'd12;

  // status from the execute logic back to the top level
  typedef struct packed {
    logic ovf;
    logic ctl_wr;
  } exec_status_t;

endpackage

FILE: rtl/fpmisc_exec.sv
// combinational execute logic: copy-sign, longword moves, conditional moves, control access
// depends on fpmisc_pkg
module fpmisc_exec
  import fpmisc_pkg::*;
(
  input  op_t          op,
  input  word_t        opa,
  input  word_t        opb,
  input  word_t        old_dst,
  input  logic         trap_en,
  input  word_t        ctl_val,
  output word_t        res,
  output exec_status_t status
);

  logic        neg;
  logic        mag_zero;
  logic [31:0] lw;
  logic        fits32;

  assign neg      = opa[63];
  assign mag_zero = (opa[62:0] == 63'd0);
  assign lw       = {opa[63:62], opa[58:29]};
  assign fits32   = (opa[63:32] == {32{opa[31]}});

  always_comb begin
    res           = old_dst;
    status.ovf    = 1'b0;
    status.ctl_wr = 1'b0;
    unique case (op)
      OP_CPYS:   res = {opa[63], opb[62:0]};
      OP_CPYSE:  res = {opa[63:52], opb[51:0]};
      OP_CPYSN:  res = {~opa[63], opb[62:0]};
      OP_CVTLQ:  res = {{32{lw[31]}}, lw};
      OP_CVTQL: begin
        res        = {opa[31:30], 3'b000, opa[29:0], 29'd0};
        status.ovf = trap_en & ~fits32;
      end
      // minus zero counts as zero in every test
      OP_CMOVEQ: res = mag_zero ? opb : old_dst;
      OP_CMOVGE: res = (~neg | mag_zero) ? opb : old_dst;
      OP_CMOVGT: res = (~neg & ~mag_zero) ? opb : old_dst;
      OP_CMOVLE: res = (neg | mag_zero) ? opb : old_dst;
      OP_CMOVLT: res = (neg & ~mag_zero) ? opb : old_dst;
      OP_CMOVNE: res = ~mag_zero ? opb : old_dst;
      OP_RD_CTL: res = ctl_val;
      OP_WR_CTL: begin
        res           = opa;
        status.ctl_wr = 1'b1;
      end
      default:   res = old_dst;
    endcase
  end

endmodule

FILE: rtl/fp_misc_operate_unit.sv
// Floating-point misc operate unit: copy-sign, cvtlq/cvtql, conditional moves and
// control-register access on 64-bit register images. An accepted transaction is
// held in an input register, executed by one level of bit-move and compare logic
// and captured in the result register; one transaction can be accepted every
// cycle unless both registers are full and out_stall is high. The control
// register is updated as a write passes from the input to the result register,
// so later reads in the stream always see it; it resets to zero.
// depends on fpmisc_pkg and fpmisc_exec
module fp_misc_operate_unit
  import fpmisc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_operation,
  input  logic [63:0] in_first_operand,
  input  logic [63:0] in_second_operand,
  input  logic [63:0] in_old_destination,
  input  logic        in_trap_on_overflow,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result,
  output logic        out_overflow_trap
);

  logic         s1_valid_r;
  op_t          s1_op_r;
  word_t        s1_opa_r;
  word_t        s1_opb_r;
  word_t        s1_old_r;
  logic         s1_trap_r;
  word_t        ctl_r;
  logic         out_valid_r;
  word_t        out_result_r;
  logic         out_ovf_r;

  word_t        exec_res;
  exec_status_t exec_st;
  logic         out_load;
  logic         adv;
  logic         in_take;

  fpmisc_exec u_exec (
    .op      (s1_op_r),
    .opa     (s1_opa_r),
    .opb     (s1_opb_r),
    .old_dst (s1_old_r),
    .trap_en (s1_trap_r),
    .ctl_val (ctl_r),
    .res     (exec_res),
    .status  (exec_st)
  );

  assign out_load = ~out_valid_r | ~out_stall;
  assign adv      = s1_valid_r & out_load;
  assign in_stall = s1_valid_r & ~out_load;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctl_r       <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
      if (adv && exec_st.ctl_wr) begin
        ctl_r <= s1_opa_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_operation;
      s1_opa_r  <= in_first_operand;
      s1_opb_r  <= in_second_operand;
      s1_old_r  <= in_old_destination;
      s1_trap_r <= in_trap_on_overflow;
    end
    if (adv) begin
      out_result_r <= exec_res;
      out_ovf_r    <= exec_st.ovf;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result        = out_result_r;
  assign out_overflow_trap = out_ovf_r;

  // the input side is held off only by a full input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // overflow only comes from a trapping cvtql
  a_ovf_source: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && exec_st.ovf) |-> (s1_trap_r && s1_op_r == OP_CVTQL))
    else $error("overflow flagged outside trapping cvtql");

  // a control write lands in the control register
  a_ctl_write: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_op_r == OP_WR_CTL) |=> (ctl_r == $past(s1_opa_r)))
    else $error("control register write lost");

  // the control register changes only on a write
  a_ctl_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(ctl_r)) |-> $past(adv && exec_st.ctl_wr))
    else $error("control register changed without a write");

endmodule

FILE: tb/fp_misc_operate_unit_tb.sv
// self-checking testbench for fp_misc_operate_unit: directed and random transactions,
// random idling on both channels, predicted results checked in order by a scoreboard class
// depends on fpmisc_pkg and the fp_misc_operate_unit rtl
module fp_misc_operate_unit_tb
  import fpmisc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // codes 13 to 15 are not assigned and leave the destination unchanged
  localparam op_t OP_RSVD13 = 4'd13;
  localparam op_t OP_RSVD14 = 4'd14;
  localparam op_t OP_RSVD15 = 4'd15;

  localparam word_t SignBit   = 64'h8000_0000_0000_0000;
  localparam word_t SignExp   = 64'hfff0_0000_0000_0000;
  localparam int    RandItems = 1200;
  localparam int    HoldCycles = 150;
  localparam int    CycleLimit = 200000;

  typedef struct packed {
    word_t result;
    logic  ovf;
  } dest_t;

  class misc_op_checker;
    word_t ctl_image;
    dest_t due_results[$];
    int    errors;

    function new();
      ctl_image = '0;
      errors = 0;
    endfunction

    // destination value and trap flag of one operate transaction
    function dest_t compute_dest(op_t op, word_t a, word_t b, word_t old, logic trap);
      dest_t      d;
      logic [31:0] lw;
      logic       neg;
      logic       mag_zero;
      neg = a[63];
      mag_zero = (a[62:0] == '0);
      d.result = old;
      d.ovf = 1'b0;
      case (op)
        OP_CPYS:   d.result = {a[63], b[62:0]};
        OP_CPYSE:  d.result = {a[63:52], b[51:0]};
        OP_CPYSN:  d.result = {~a[63], b[62:0]};
        OP_CVTLQ: begin
          lw = {a[63:62], a[58:29]};
          d.result = {{32{lw[31]}}, lw};
        end
        OP_CVTQL: begin
          d.result = {a[31:30], 3'b000, a[29:0], 29'd0};
          d.ovf = trap && (a[63:32] != {32{a[31]}});
        end
        OP_CMOVEQ: d.result = mag_zero ? b : old;
        OP_CMOVGE: d.result = (!neg || mag_zero) ? b : old;
        OP_CMOVGT: d.result = (!neg && !mag_zero) ? b : old;
        OP_CMOVLE: d.result = (neg || mag_zero) ? b : old;
        OP_CMOVLT: d.result = (neg && !mag_zero) ? b : old;
        OP_CMOVNE: d.result = !mag_zero ? b : old;
        OP_RD_CTL: d.result = ctl_image;
        OP_WR_CTL: begin
          ctl_image = a;
          d.result = a;
        end
        default:   d.result = old;
      endcase
      return d;
    endfunction

    function void note_issue(op_t op, word_t a, word_t b, word_t old, logic trap);
      due_results.push_back(compute_dest(op, a, b, old, trap));
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_writeback(word_t res, logic ovf);
      dest_t d;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", res));
      end else begin
        d = due_results.pop_front();
        if (res !== d.result)
          report_mismatch($sformatf("result %h, predicted %h", res, d.result));
        if (ovf !== d.ovf)
          report_mismatch($sformatf("overflow_trap %b, predicted %b", ovf, d.ovf));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_operation;
  logic [63:0] in_first_operand;
  logic [63:0] in_second_operand;
  logic [63:0] in_old_destination;
  logic        in_trap_on_overflow;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_result;
  logic        out_overflow_trap;

  misc_op_checker chk = new();
  bit no_idle;
  bit hold_req;
  int cycles;

  fp_misc_operate_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_first_operand    (in_first_operand),
    .in_second_operand   (in_second_operand),
    .in_old_destination  (in_old_destination),
    .in_trap_on_overflow (in_trap_on_overflow),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result          (out_result),
    .out_overflow_trap   (out_overflow_trap)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // operand images biased toward zeros, sign-only values and 32-bit boundaries
  function automatic word_t pick_word();
    logic [31:0] w32;
    w32 = $urandom;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SignBit;
      2: return '1;
      3: return ~SignBit;
      4: return {{32{w32[31]}}, w32};
      5: return word_t'(1) << $urandom_range(0, 63);
      6: return {$urandom_range(0, 1) ? 32'hffff_ffff : 32'h0, w32};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task send_op(op_t op, word_t a, word_t b, word_t old, logic trap);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= op;
    in_first_operand    <= a;
    in_second_operand   <= b;
    in_old_destination  <= old;
    in_trap_on_overflow <= trap;
    do @(posedge clk); while (in_stall);
    chk.note_issue(op, a, b, old, trap);
  endtask

  task send_random();
    send_op(op_t'($urandom_range(0, 15)), pick_word(), pick_word(), pick_word(),
            1'($urandom_range(0, 1)));
  endtask

  // receiver side: per-result stall draw, with one long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 6);
      if (hold_req) begin
        hold_req = 1'b0;
        n = HoldCycles;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        chk.check_writeback(out_result, out_overflow_trap);
    end
  end

  initial begin
    no_idle = 1'b0;
    hold_req = 1'b0;
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_operation        <= OP_CPYS;
    in_first_operand    <= '0;
    in_second_operand   <= '0;
    in_old_destination  <= '0;
    in_trap_on_overflow <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset value of the control register, copy-sign, converts
    send_op(OP_RD_CTL, '1, '1, '1, 1'b1);
    send_op(OP_CPYS, '1, '0, '1, 1'b0);
    send_op(OP_CPYSE, SignExp, '1, '0, 1'b0);
    send_op(OP_CPYSN, '0, '0, '1, 1'b1);
    send_op(OP_CVTLQ, '1, '0, '0, 1'b0);
    send_op(OP_CVTLQ, 64'h4000_0000_2000_0000, '1, '1, 1'b0);
    send_op(OP_CVTQL, 64'hffff_ffff_8000_0000, '0, '0, 1'b1);
    send_op(OP_CVTQL, 64'h0000_0000_8000_0000, '0, '0, 1'b1);
    send_op(OP_CVTQL, 64'h0000_0000_8000_0000, '0, '0, 1'b0);
    send_op(OP_CVTQL, '1, '0, '0, 1'b1);
    // conditional moves: minus zero counts as zero
    send_op(OP_CMOVEQ, SignBit, 64'h1111, 64'h2222, 1'b0);
    send_op(OP_CMOVNE, SignBit, 64'h1111, 64'h2222, 1'b0);
    send_op(OP_CMOVLT, SignBit, 64'h1111, 64'h2222, 1'b0);
    send_op(OP_CMOVLT, '1, 64'h1111, 64'h2222, 1'b0);
    send_op(OP_CMOVGE, '1, 64'h1111, 64'h2222, 1'b0);
    send_op(OP_CMOVGT, 64'h1, 64'h1111, 64'h2222, 1'b0);
    send_op(OP_CMOVGT, '0, 64'h1111, 64'h2222, 1'b0);
    send_op(OP_CMOVLE, SignBit, 64'h1111, 64'h2222, 1'b0);
    // control write seen by the very next read
    send_op(OP_WR_CTL, '1, '0, '0, 1'b1);
    send_op(OP_RD_CTL, '0, '0, '0, 1'b0);
    send_op(OP_RSVD13, '1, '1, 64'h3333, 1'b1);
    send_op(OP_RSVD14, '0, '1, 64'h4444, 1'b1);
    send_op(OP_RSVD15, '1, '0, '0, 1'b1);

    for (int i = 0; i < RandItems; i++) begin
      if (i % 150 == 0)
        no_idle = ($urandom_range(0, 2) == 0);
      if (i == 500) begin
        // receiver holds off while the sender keeps pushing back to back
        no_idle = 1'b1;
        hold_req = 1'b1;
      end
      if (i == 900) begin
        in_valid <= 1'b0;
        while (chk.due_results.size() != 0) @(posedge clk);
      end
      send_random();
    end
    in_valid <= 1'b0;

    while (chk.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (chk.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/fpmisc_pkg.sv
rtl/fpmisc_exec.sv
rtl/fp_misc_operate_unit.sv
tb/fp_misc_operate_unit_tb.sv
